// File: rtl/tspg_pkg.sv
// Shared types and constants for the three-axis step pulse generator.
package tspg_pkg;

	localparam int BYTE_W      = 8;
	localparam int DELAY_W     = 16;
	localparam int WAIT_W      = 17;
	localparam int AXIS_BYTES  = 4;
	localparam int OUT_AXES    = 3;
	localparam int QUEUE_DEPTH = 2;

	// What a queued transaction asks the back end to do.
	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] byte_value;
	} item_t;

	// Handshake between front end, queue and back end.
	typedef struct packed {
		logic  valid;
		item_t item;
	} push_t;

	typedef struct packed {
		logic [OUT_AXES-1:0] step;
		logic [OUT_AXES-1:0] dir;
		logic                busy_res;
		logic                byte_dropped;
	} result_t;

endpackage

// File: rtl/tspg_if.sv
// Channel interfaces: input items and result items.
interface tspg_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] byte_value;

	modport source (output valid, output cmd, output byte_value, input ready);
	modport sink (input valid, input cmd, input byte_value, output ready);
endinterface

interface tspg_out_if;
	logic valid;
	logic ready;
	logic step_x;
	logic step_y;
	logic step_z;
	logic dir_x;
	logic dir_y;
	logic dir_z;
	logic busy_res;
	logic byte_dropped;

	modport source (output valid, output step_x, output step_y, output step_z,
		output dir_x, output dir_y, output dir_z, output busy_res,
		output byte_dropped, input ready);
	modport sink (input valid, input step_x, input step_y, input step_z,
		input dir_x, input dir_y, input dir_z, input busy_res,
		input byte_dropped, output ready);
endinterface

// File: rtl/tspg_front.sv
// Front end: accepts input transactions, classifies them, feeds the queue.
module tspg_front
	import tspg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tspg_in_if.sink      items,
	output push_t        push,
	input  logic         push_ready
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign items.ready = !valid_s1 || push_ready;
	assign take        = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind       <= items.cmd ? KIND_TICK : KIND_BYTE;
			item_s1.byte_value <= items.byte_value;
		end
	end

	assign push.valid = valid_s1;
	assign push.item  = item_s1;

endmodule

// File: rtl/tspg_queue.sv
// Short FIFO between front end and back end.
module tspg_queue
	import tspg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  push_ready,
	output push_t head,
	input  logic  pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

endmodule

// File: rtl/tspg_back.sv
// Back end: packet assembly, step/wait sequencing and the result register.
module tspg_back
	import tspg_pkg::*;
#(
	parameter int NUM_AXES    = 3,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       head,
	output logic        pop,
	tspg_out_if.source  results
);

	localparam int PKT_BYTES = AXIS_BYTES * NUM_AXES + 2;
	localparam int IDX_W     = $clog2(PKT_BYTES);
	localparam int OUT_N     = (NUM_AXES < OUT_AXES) ? NUM_AXES : OUT_AXES;
	localparam int LANE_W    = 8 * AXIS_BYTES;

	logic [IDX_W-1:0]       byte_index_q, byte_index_d;
	logic [COUNT_WIDTH-1:0] remaining_q [NUM_AXES];
	logic [COUNT_WIDTH-1:0] remaining_d [NUM_AXES];
	logic [DELAY_W-1:0]     delay_q, delay_d;
	logic [WAIT_W-1:0]      wait_q, wait_d;
	logic                   moving_q, moving_d;
	logic [OUT_N-1:0]       dir_q, dir_d;
	logic                   out_valid_q;
	result_t                out_q, res_d;

	assign pop = head.valid && (!out_valid_q || results.ready);

	always_comb begin
		logic [LANE_W-1:0]       lane_bits;
		logic [COUNT_WIDTH-1:0]  r;
		logic                    rem_zero;
		logic                    new_zero;
		logic [NUM_AXES-1:0]     steps;
		logic                    dropped;

		byte_index_d = byte_index_q;
		delay_d      = delay_q;
		wait_d       = wait_q;
		moving_d     = moving_q;
		dir_d        = dir_q;
		r            = '0;
		steps        = '0;
		dropped      = 1'b0;
		rem_zero     = 1'b1;
		new_zero     = 1'b1;
		lane_bits    = LANE_W'(head.item.byte_value) << {byte_index_q[1:0], 3'b000};
		for (int a = 0; a < NUM_AXES; a++) begin
			remaining_d[a] = remaining_q[a];
			if (remaining_q[a] != '0) begin
				rem_zero = 1'b0;
			end
		end

		if (head.item.kind == KIND_BYTE) begin
			if (moving_q) begin
				dropped = 1'b1;
			end else begin
				// first byte of a packet clears the previous move
				if (byte_index_q == '0) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						remaining_d[a] = '0;
					end
					delay_d = '0;
				end
				if (byte_index_q < IDX_W'(AXIS_BYTES * NUM_AXES)) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						if (byte_index_q[IDX_W-1:2] == (IDX_W-2)'(a)) begin
							remaining_d[a] = remaining_d[a] | lane_bits[COUNT_WIDTH-1:0];
						end
					end
				end else if (byte_index_q == IDX_W'(AXIS_BYTES * NUM_AXES)) begin
					delay_d[7:0] = head.item.byte_value;
				end else begin
					delay_d[15:8] = head.item.byte_value;
				end
				if (byte_index_q == IDX_W'(PKT_BYTES - 1)) begin
					byte_index_d = '0;
					wait_d       = '0;
					for (int a = 0; a < NUM_AXES; a++) begin
						if (remaining_d[a] != '0) begin
							new_zero = 1'b0;
						end
					end
					moving_d = !new_zero;
				end else begin
					byte_index_d = byte_index_q + 1'b1;
				end
			end
		end else if (moving_q) begin
			if (wait_q == '0) begin
				// step tick
				for (int a = 0; a < NUM_AXES; a++) begin
					r = remaining_q[a];
					if (r != '0) begin
						steps[a] = 1'b1;
						if (r[COUNT_WIDTH-1]) begin
							remaining_d[a] = r + 1'b1;
						end else begin
							remaining_d[a] = r - 1'b1;
						end
					end
				end
				for (int a = 0; a < OUT_N; a++) begin
					if (steps[a]) begin
						dir_d[a] = remaining_q[a][COUNT_WIDTH-1];
					end
				end
				wait_d = (delay_q == '0) ? {1'b1, {DELAY_W{1'b0}}} : {1'b0, delay_q};
			end else begin
				wait_d = wait_q - 1'b1;
				if (wait_d == '0 && rem_zero) begin
					moving_d = 1'b0;
				end
			end
		end

		res_d = '0;
		for (int a = 0; a < OUT_N; a++) begin
			res_d.step[a] = steps[a];
			res_d.dir[a]  = dir_d[a];
		end
		res_d.busy_res     = moving_d;
		res_d.byte_dropped = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			for (int a = 0; a < NUM_AXES; a++) begin
				remaining_q[a] <= '0;
			end
			delay_q     <= '0;
			wait_q      <= '0;
			moving_q    <= 1'b0;
			dir_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				byte_index_q <= byte_index_d;
				for (int a = 0; a < NUM_AXES; a++) begin
					remaining_q[a] <= remaining_d[a];
				end
				delay_q  <= delay_d;
				wait_q   <= wait_d;
				moving_q <= moving_d;
				dir_q    <= dir_d;
			end
			if (!out_valid_q || results.ready) begin
				out_valid_q <= head.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_d;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.step_x       = out_q.step[0];
	assign results.step_y       = out_q.step[1];
	assign results.step_z       = out_q.step[2];
	assign results.dir_x        = out_q.dir[0];
	assign results.dir_y        = out_q.dir[1];
	assign results.dir_z        = out_q.dir[2];
	assign results.busy_res     = out_q.busy_res;
	assign results.byte_dropped = out_q.byte_dropped;

endmodule

// File: rtl/three_axis_step_pulse_generator.sv
// Top level of the three-axis step/direction pulse generator.
//
// Channels: "items" carries one transaction per input item, cmd 0 for a
// packet byte (byte_value) and cmd 1 for a delay-loop tick. "results" returns
// exactly one transaction per item: step pulses, held direction levels, busy
// and a dropped-byte flag. Both use valid/ready; a transaction moves on a
// clock edge with both high.
// Packets are 4*NUM_AXES+2 little-endian bytes: a signed count per axis, then
// a 16-bit delay (0 means 65536 ticks). Bytes during a move are dropped.
// An item passes three register stages (input stage, queue entry, result register).
// Throughput: one item per cycle while results are taken; the back end does
// one compare and one increment/decrement per axis for each item at once.
// Reset (arst_n low) clears the packet index, counts, delay, wait counter,
// direction levels and all valid flags.
// A stalled receiver holds the result register; the back end stops popping,
// the two-entry queue and the input stage fill, then ready drops.
module three_axis_step_pulse_generator
	import tspg_pkg::*;
#(
	parameter int NUM_AXES    = 3,
	parameter int COUNT_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	tspg_in_if.sink    items,
	tspg_out_if.source results
);

	push_t front_push;
	logic  queue_ready;
	push_t queue_head;
	logic  back_pop;

	tspg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push       (front_push),
		.push_ready (queue_ready)
	);

	tspg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_push),
		.push_ready (queue_ready),
		.head       (queue_head),
		.pop        (back_pop)
	);

	tspg_back #(
		.NUM_AXES    (NUM_AXES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (queue_head),
		.pop     (back_pop),
		.results (results)
	);

endmodule
